FILE: design/ipdt_pkg.sv
package ipdt_pkg;

   // Phase resolution in bits and number of CORDIC iterations.
   localparam int PHASE_BITS   = 16;
   localparam int CORDIC_STEPS = 16;

   // Field widths.
   localparam int IN_W    = 48;
   localparam int LOAD_W  = 32;
   localparam int DIST_W  = 32;
   localparam int HW_W    = 16;
   localparam int OUT_PH_W = 16;

   // CORDIC datapath: the sample is negated and then grows by the CORDIC gain.
   localparam int XW = IN_W + 4;
   localparam int KW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int ATAN_IW = 5;

   // Distance accumulator with PHASE_BITS fraction bits.
   localparam int AW = DIST_W + PHASE_BITS;
   localparam int PW = PHASE_BITS + HW_W + 1;

   // Queue between the front and the back.
   localparam int QDEPTH = 2;
   localparam int QPW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   // Reset value of the half wavelength register.
   localparam logic [HW_W-1:0] HW_RESET = 16'd9800;

   // Request actions.
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_LOAD   = 1'b1;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      logic                     load;
      logic                     zero;
      logic signed [XW-1:0]     x;
      logic signed [XW-1:0]     y;
      logic [31:0]              z;
      logic signed [LOAD_W-1:0] distance_load;
   } work_type;

   // Arctangent of 2^-k in turns scaled by 2^32.
   function automatic logic [31:0] atan_turns(input logic [ATAN_IW-1:0] k);
      logic [31:0] a;
      case (k)
         5'd0:    a = 32'd536870912;
         5'd1:    a = 32'd316933406;
         5'd2:    a = 32'd167458907;
         5'd3:    a = 32'd85004756;
         5'd4:    a = 32'd42667331;
         5'd5:    a = 32'd21354465;
         5'd6:    a = 32'd10679838;
         5'd7:    a = 32'd5340245;
         5'd8:    a = 32'd2670163;
         5'd9:    a = 32'd1335087;
         5'd10:   a = 32'd667544;
         5'd11:   a = 32'd333772;
         5'd12:   a = 32'd166886;
         5'd13:   a = 32'd83443;
         5'd14:   a = 32'd41722;
         5'd15:   a = 32'd20861;
         5'd16:   a = 32'd10430;
         5'd17:   a = 32'd5215;
         5'd18:   a = 32'd2608;
         5'd19:   a = 32'd1304;
         5'd20:   a = 32'd652;
         5'd21:   a = 32'd326;
         5'd22:   a = 32'd163;
         5'd23:   a = 32'd81;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage

FILE: design/ipdt_front.sv
module ipdt_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic                             req_action,
   input  logic signed [ipdt_pkg::IN_W-1:0]   req_i_value,
   input  logic signed [ipdt_pkg::IN_W-1:0]   req_q_value,
   input  logic signed [ipdt_pkg::LOAD_W-1:0] req_distance_load,
   output ipdt_pkg::work_type               work,
   output logic                             work_push,
   input  logic                             work_full
);

   ipdt_pkg::work_type work_ff, work_in;
   logic               valid_ff, valid_in;
   logic               accept;
   logic signed [ipdt_pkg::XW-1:0] i_ext, q_ext;

   // The stage is blocked only when it holds a request the queue cannot take.
   assign req_full  = valid_ff & work_full;
   assign accept    = req_push & ~req_full;
   assign work_push = valid_ff & ~work_full;
   assign work      = work_ff;

   // Classify the request and pre-rotate vectors in the left half plane.
   always_comb begin
      i_ext = ipdt_pkg::XW'(req_i_value);
      q_ext = ipdt_pkg::XW'(req_q_value);
      work_in.load          = (req_action == ipdt_pkg::ACT_LOAD);
      work_in.zero          = (req_i_value == '0) && (req_q_value == '0);
      work_in.distance_load = req_distance_load;
      if (req_i_value[ipdt_pkg::IN_W-1]) begin
         work_in.x = -i_ext;
         work_in.y = -q_ext;
         work_in.z = 32'h8000_0000;
      end else begin
         work_in.x = i_ext;
         work_in.y = q_ext;
         work_in.z = 32'h0;
      end
   end

   // Stage valid bit.
   assign valid_in = accept | (valid_ff & work_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         work_ff <= work_in;
      end
   end

endmodule

FILE: design/ipdt_queue.sv
module ipdt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ipdt_pkg::work_type push_data,
   output logic               full,
   input  logic               pop,
   output ipdt_pkg::work_type pop_data,
   output logic               empty
);

   ipdt_pkg::work_type             entry_ff [ipdt_pkg::QDEPTH];
   logic [ipdt_pkg::QPW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ipdt_pkg::QPW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ipdt_pkg::QCW-1:0]       count_ff, count_in;
   logic                           do_push, do_pop;

   assign full     = (count_ff == ipdt_pkg::QCW'(ipdt_pkg::QDEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ipdt_pkg::QPW'(ipdt_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ipdt_pkg::QPW'(ipdt_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/ipdt_back.sv
module ipdt_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ipdt_pkg::HW_W-1:0]         half_wl,
   input  ipdt_pkg::work_type                work,
   input  logic                              work_empty,
   output logic                              work_pop,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [ipdt_pkg::OUT_PH_W-1:0]     rsp_phase_turns,
   output logic signed [ipdt_pkg::DIST_W-1:0] rsp_distance_um,
   output logic                              rsp_saturated
);

   localparam int PB = ipdt_pkg::PHASE_BITS;
   localparam int AW = ipdt_pkg::AW;
   localparam int XW = ipdt_pkg::XW;
   localparam int KW = ipdt_pkg::KW;
   localparam int PW = ipdt_pkg::PW;
   localparam logic [KW-1:0] K_LAST = KW'(ipdt_pkg::CORDIC_STEPS - 1);
   localparam logic [31:0]   ROUND_ONE = 32'd1 << (31 - PB);
   localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CORDIC = 6'b000010,
      S_ROUND  = 6'b000100,
      S_MULT   = 6'b001000,
      S_SUM    = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type                 state_ff, state_in;
   logic [KW-1:0]             k_ff, k_in;
   logic signed [XW-1:0]      x_ff, x_in, y_ff, y_in;
   logic [31:0]               z_ff, z_in;
   logic signed [PB-1:0]      step_ff, step_in;
   logic signed [PW-1:0]      prod_ff, prod_in;
   logic signed [AW-1:0]      acc_ff, acc_in;
   logic [PB-1:0]             last_ff, last_in;
   logic                      sat_ff, sat_in;
   logic                      out_valid_ff, out_valid_in;
   logic [ipdt_pkg::OUT_PH_W-1:0]      out_ph_ff;
   logic signed [ipdt_pkg::DIST_W-1:0] out_dist_ff;
   logic                               out_sat_ff;
   logic                      out_load;
   logic signed [XW-1:0]      dx, dy;
   logic [31:0]               atan_k, z_rnd;
   logic [PB-1:0]             ph;
   logic signed [AW:0]        sum;
   logic [PB+ipdt_pkg::OUT_PH_W-1:0] ph_wide;

   assign work_pop = (state_ff == S_IDLE) & ~work_empty;
   assign out_load = (state_ff == S_DONE) & (~out_valid_ff | rsp_pop);

   // Shared CORDIC step terms and phase rounding.
   assign dx     = y_ff >>> k_ff;
   assign dy     = x_ff >>> k_ff;
   assign atan_k = ipdt_pkg::atan_turns(ipdt_pkg::ATAN_IW'(k_ff));
   assign z_rnd  = z_ff + ROUND_ONE;
   assign ph     = z_rnd[31:32-PB];
   assign sum    = (AW+1)'(acc_ff) + (AW+1)'(prod_ff);

   // Sequencer for one request.
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      step_in  = step_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      last_in  = last_ff;
      sat_in   = sat_ff;
      case (state_ff)
         S_IDLE: begin
            if (!work_empty) begin
               x_in = work.x;
               y_in = work.y;
               z_in = work.z;
               k_in = '0;
               if (work.load) begin
                  acc_in   = {work.distance_load, {PB{1'b0}}};
                  sat_in   = 1'b0;
                  state_in = S_DONE;
               end else if (work.zero) begin
                  z_in     = '0;
                  state_in = S_ROUND;
               end else begin
                  state_in = S_CORDIC;
               end
            end
         end
         S_CORDIC: begin
            if (!y_ff[XW-1]) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_k;
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_k;
            end
            k_in = k_ff + 1'b1;
            if (k_ff == K_LAST) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            // The wrapped difference read as signed is the unwrapped step.
            step_in  = $signed(ph - last_ff);
            last_in  = ph;
            state_in = S_MULT;
         end
         S_MULT: begin
            prod_in  = PW'(step_ff * $signed({1'b0, half_wl}));
            state_in = S_SUM;
         end
         S_SUM: begin
            if (sum[AW] != sum[AW-1]) begin
               acc_in = sum[AW] ? ACC_MIN : ACC_MAX;
               sat_in = 1'b1;
            end else begin
               acc_in = sum[AW-1:0];
               sat_in = 1'b0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         acc_ff   <= '0;
         last_ff  <= '0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         acc_ff   <= acc_in;
         last_ff  <= last_in;
         sat_ff   <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
   end

   // Result register decouples the back from the consumer.
   assign out_valid_in = out_load | (out_valid_ff & ~rsp_pop);
   assign ph_wide      = {last_ff, {ipdt_pkg::OUT_PH_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ph_ff   <= ph_wide[PB+ipdt_pkg::OUT_PH_W-1:PB];
         out_dist_ff <= acc_ff[AW-1:PB];
         out_sat_ff  <= sat_ff;
      end
   end

   assign rsp_empty       = ~out_valid_ff;
   assign rsp_phase_turns = out_ph_ff;
   assign rsp_distance_um = out_dist_ff;
   assign rsp_saturated   = out_sat_ff;

`ifndef ASSERT_OFF
   // A new request is only taken from the queue while the sequencer is idle.
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      work_pop |-> (state_ff == S_IDLE))
      else $error("request taken while sequencer busy");

   // The last CORDIC iteration always hands over to rounding.
   a_cordic_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CORDIC && k_ff == K_LAST) |=> (state_ff == S_ROUND))
      else $error("CORDIC did not finish after its last iteration");

   // A saturation flag means the accumulator sits at one of its limits.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> (acc_ff == ACC_MAX || acc_ff == ACC_MIN))
      else $error("saturation flagged with accumulator inside range");

   // A load request yields an unsaturated result.
   a_load_nosat: assert property (@(posedge clock) disable iff (reset)
      (work_pop && work.load) |=> !sat_ff)
      else $error("load request left saturation flag set");
`endif

endmodule

FILE: design/iq_phase_distance_tracker_unit.sv
// Phase-based distance tracker. Each request carries one baseband I/Q sample
// or a distance load. For a sample, the block finds the phase with a
// sixteen-step iterative CORDIC, unwraps it against the previous phase into a
// step of [-1/2, +1/2) turn (an exact half turn counts as -1/2), multiplies the
// step by the half wavelength register and adds it to a saturating distance
// accumulator with 16 fraction bits. A load request overwrites the distance and
// returns the held phase. Each request gives one response on the rsp_ side.
// A sample steps the back end through idle, the CORDIC iterations (which
// share one datapath), round, multiply, sum and done; a zero vector skips
// the iterations, and a load goes from idle straight to done. A response
// that is not popped holds the back end until the response register frees.
// The front stage and a two-entry queue keep taking requests while the back
// end works, and a response register holds the oldest result until popped.
// The half wavelength register resets to 9800 um; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module iq_phase_distance_tracker_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_action,
   input  logic signed [ipdt_pkg::IN_W-1:0]   req_i_value,
   input  logic signed [ipdt_pkg::IN_W-1:0]   req_q_value,
   input  logic signed [ipdt_pkg::LOAD_W-1:0] req_distance_load,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [ipdt_pkg::OUT_PH_W-1:0]     rsp_phase_turns,
   output logic signed [ipdt_pkg::DIST_W-1:0] rsp_distance_um,
   output logic                              rsp_saturated,
   input  logic                              csr_we,
   input  logic [ipdt_pkg::HW_W-1:0]         csr_wdata
);

   logic [ipdt_pkg::HW_W-1:0] half_wl_ff;
   ipdt_pkg::work_type        front_work, queue_work;
   logic                      front_push, queue_full, queue_empty, back_pop;

   // Half wavelength configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         half_wl_ff <= ipdt_pkg::HW_RESET;
      end else if (csr_we) begin
         half_wl_ff <= csr_wdata;
      end
   end

   // Front end accepts and classifies requests.
   ipdt_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_action        (req_action),
      .req_i_value       (req_i_value),
      .req_q_value       (req_q_value),
      .req_distance_load (req_distance_load),
      .work              (front_work),
      .work_push         (front_push),
      .work_full         (queue_full)
   );

   // Queue between front and back ends.
   ipdt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_work),
      .full      (queue_full),
      .pop       (back_pop),
      .pop_data  (queue_work),
      .empty     (queue_empty)
   );

   // Back end runs the CORDIC and the distance update.
   ipdt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .half_wl         (half_wl_ff),
      .work            (queue_work),
      .work_empty      (queue_empty),
      .work_pop        (back_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_phase_turns (rsp_phase_turns),
      .rsp_distance_um (rsp_distance_um),
      .rsp_saturated   (rsp_saturated)
   );

endmodule
